### hw/rtl/hstc_pkg.sv
// ----------------------------------------------------------------------------
// hstc_pkg: shared types and constants of the transition counter
// Request payloads, controller commands and status, and hash constants.
// ----------------------------------------------------------------------------
package hstc_pkg;

  localparam int unsigned MapEntriesDef = 65536;
  localparam int unsigned NumVarsDef    = 256;
  localparam int unsigned FeedDef       = 16;

  localparam logic [63:0] MixMul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMul2 = 64'h94d049bb133111eb;

  localparam logic [2:0] OP_MACHINE = 3'd0;
  localparam logic [2:0] OP_SUB     = 3'd1;
  localparam logic [2:0] OP_SINGLE  = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_NEWRUN  = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic [15:0]        var_id;
    logic signed [31:0] var_value;
    logic [15:0]        read_index;
  } in_req_t;

  typedef struct packed {
    logic        fed;
    logic [15:0] map_index;
    logic [7:0]  count_value;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_MIX1, ST_MIX2, ST_MIX3, ST_MIX4,
    ST_MIX5, ST_MAPRD, ST_MAPWR, ST_OUT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic scan_step;
    logic append;
    logic mix1;
    logic mix2;
    logic mix3;
    logic mix4;
    logic mix5;
    logic map_rd;
    logic map_wr;
    logic make_zero;
    logic out_valid;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic found;
    logic room;
    logic in_range;
  } ctl_sts_t;

endpackage

### hw/rtl/hashed_state_transition_counter.sv
// ----------------------------------------------------------------------------
// hashed_state_transition_counter: top level
// Counts hashed transitions of monitored variables in an 8-bit counter map.
// ----------------------------------------------------------------------------
// One request at a time. After reset a sweep clears the counter memory and the
// per-variable fill counts, one entry per cycle, before the first request is
// taken. Ops 0 and 1 pass through accept, five hash steps through 32-bit
// multipliers, counter read and write, then output; op 2 first scans the n stored
// values of its variable one memory read at a time; op 3 reads the counter
// before output, and ops 4 to 7 go from accept straight to output.
module hashed_state_transition_counter #(
  parameter int unsigned NUM_VARS    = hstc_pkg::NumVarsDef,
  parameter int unsigned FEED        = hstc_pkg::FeedDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hstc_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hstc_pkg::out_req_t out_data
);
  import hstc_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  hstc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_op(in_data.op),
    .out_valid, .out_ready, .sts, .cmd
  );

  hstc_dp #(
    .NUM_VARS(NUM_VARS), .FEED(FEED)
  ) u_dp (
    .clk, .rst_n, .in_data, .cmd, .sts, .out_data
  );

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accept while result pending");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data)) else $error("result moved");

endmodule

### hw/rtl/hstc_ctrl.sv
// ----------------------------------------------------------------------------
// hstc_ctrl: sequencing state machine
// Walks each request through the steps its op needs: table scan, hash, counter update.
// ----------------------------------------------------------------------------
module hstc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_op,
  output logic                out_valid,
  input  logic                out_ready,
  input  hstc_pkg::ctl_sts_t  sts,
  output hstc_pkg::ctl_cmd_t  cmd
);
  import hstc_pkg::*;

  state_t state_r, state_nxt;
  logic [2:0] op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      op_r    <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          op_nxt   = in_op;
          if (in_op == OP_MACHINE || in_op == OP_SUB) begin
            state_nxt = ST_MIX1;
          end else if (in_op == OP_SINGLE) begin
            state_nxt = ST_SCAN;
          end else if (in_op == OP_READ) begin
            state_nxt = ST_MAPRD;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_SCAN: begin
        if (!sts.in_range) begin
          cmd.make_zero = 1'b1;
          state_nxt = ST_OUT;
        end else if (sts.found) begin
          state_nxt = ST_MIX1;
        end else if (sts.scan_done) begin
          if (sts.room) begin
            cmd.append = 1'b1;
            state_nxt  = ST_MIX1;
          end else begin
            cmd.make_zero = 1'b1;
            state_nxt = ST_OUT;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_MIX1: begin cmd.mix1 = 1'b1; state_nxt = ST_MIX2; end
      ST_MIX2: begin cmd.mix2 = 1'b1; state_nxt = ST_MIX3; end
      ST_MIX3: begin cmd.mix3 = 1'b1; state_nxt = ST_MIX4; end
      ST_MIX4: begin cmd.mix4 = 1'b1; state_nxt = ST_MIX5; end
      ST_MIX5: begin cmd.mix5 = 1'b1; state_nxt = ST_MAPRD; end
      ST_MAPRD: begin
        cmd.map_rd = 1'b1;
        state_nxt = (op_r == OP_READ) ? ST_OUT : ST_MAPWR;
      end
      ST_MAPWR: begin
        cmd.map_wr = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/hstc_dp.sv
// ----------------------------------------------------------------------------
// hstc_dp: datapath of the transition counter
// Per-variable value tables, split hash multiplier and counter memory.
// ----------------------------------------------------------------------------
module hstc_dp #(
  parameter int unsigned NUM_VARS    = hstc_pkg::NumVarsDef,
  parameter int unsigned FEED        = hstc_pkg::FeedDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hstc_pkg::in_req_t   in_data,
  input  hstc_pkg::ctl_cmd_t  cmd,
  output hstc_pkg::ctl_sts_t  sts,
  output hstc_pkg::out_req_t  out_data
);
  import hstc_pkg::*;

  localparam int unsigned MAP_ENTRIES = MapEntriesDef;
  localparam int MW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int VW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int FW = (FEED > 1) ? $clog2(FEED) : 1;
  localparam int CW = $clog2(FEED + 1);
  localparam int TW = VW + FW;

  // Counter memory; cleared by a sweep after reset.
  logic [7:0]    cmap [MAP_ENTRIES];
  logic [31:0]   tags [NUM_VARS << FW];
  // Per-variable fill counts; cleared by the same sweep.
  logic [CW-1:0] cnt_r [NUM_VARS];

  logic [MW:0]   clr_r;
  logic [31:0]   mstate_r, mprev_r, sprev_r;
  logic          mstart_r, sstart_r;
  logic [2:0]    op_r;
  logic [15:0]   id_r;
  logic [31:0]   tag_r;
  logic [CW-1:0] pos_r, n_r;
  logic [31:0]   tagrd_r;
  logic          rdv_r, found_r;
  logic [63:0]   x_r, p_r;
  logic [MW-1:0] idx_r;
  logic [7:0]    cval_r;
  out_req_t      res_r;

  logic [31:0] tag_w, v_sub, prior_w;
  logic [TW-1:0] rd_addr, wr_addr;
  logic [63:0] xs;

  assign tag_w = {in_data.var_id, 16'h0} + 32'(unsigned'(in_data.var_value));
  assign v_sub = mstate_r ^ tag_r;

  assign rd_addr = {id_r[VW-1:0], pos_r[FW-1:0]};
  assign wr_addr = {id_r[VW-1:0], n_r[FW-1:0]};

  assign sts.clear_done = clr_r[MW];
  assign sts.in_range   = 32'(id_r) < NUM_VARS;
  assign sts.found      = found_r;
  assign sts.scan_done  = !rdv_r && (pos_r >= n_r);
  assign sts.room       = 32'(n_r) < FEED;
  assign out_data       = res_r;

  // Table scan: one registered read per cycle, compare on the next.
  always_ff @(posedge clk) begin
    if (cmd.scan_step && pos_r < n_r) begin
      tagrd_r <= tags[rd_addr];
    end
    if (cmd.append) begin
      tags[wr_addr] <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step && !clr_r[MW] && 32'(clr_r) < NUM_VARS) begin
      cnt_r[clr_r[VW-1:0]] <= '0;
    end else if (cmd.append) begin
      cnt_r[id_r[VW-1:0]] <= n_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r    <= '0;
      mstate_r <= '0;
      mprev_r  <= '0;
      sprev_r  <= '0;
      mstart_r <= 1'b0;
      sstart_r <= 1'b0;
      rdv_r    <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      if (cmd.clear_step && !clr_r[MW]) begin
        clr_r <= clr_r + 1'b1;
      end
      rdv_r <= cmd.scan_step && (pos_r < n_r);
      if (rdv_r && tagrd_r == tag_r) begin
        found_r <= 1'b1;
      end
      if (cmd.load) begin
        found_r <= 1'b0;
        rdv_r   <= 1'b0;
        if (in_data.op == OP_NEWRUN) begin
          mstate_r <= '0;
          mprev_r  <= '0;
          sprev_r  <= '0;
          mstart_r <= 1'b0;
          sstart_r <= 1'b0;
        end
      end
      if (cmd.mix1) begin
        if (op_r == OP_MACHINE) begin
          mstate_r <= tag_r;
          mprev_r  <= tag_r;
          mstart_r <= 1'b1;
        end else begin
          sprev_r  <= v_sub;
          sstart_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_data.op;
      id_r   <= in_data.var_id;
      tag_r  <= tag_w;
      pos_r  <= '0;
    end else if (cmd.scan_step && pos_r < n_r) begin
      pos_r <= pos_r + 1'b1;
    end
    if (cmd.load) begin
      n_r <= (32'(in_data.var_id) < NUM_VARS) ? cnt_r[in_data.var_id[VW-1:0]] : '0;
    end
  end

  // Hash: x ^= x>>30; two 64x64 low products, each split into 32-bit halves.
  always_comb begin
    if (op_r == OP_MACHINE) begin
      prior_w = mstart_r ? mprev_r : tag_r;
    end else begin
      prior_w = sstart_r ? sprev_r : v_sub;
    end
  end

  assign xs = x_r;

  always_ff @(posedge clk) begin
    if (cmd.mix1) begin
      logic [63:0] pk;
      pk  = (op_r == OP_MACHINE) ? {prior_w, tag_r} : {prior_w, v_sub};
      x_r <= pk ^ (pk >> 30);
    end
    if (cmd.mix2) begin
      p_r <= 64'(xs[31:0] * MixMul1[31:0]);
    end
    if (cmd.mix3) begin
      logic [31:0] hi;
      logic [63:0] m;
      hi = 32'(xs[63:32] * MixMul1[31:0]) + 32'(xs[31:0] * MixMul1[63:32]);
      m  = p_r + {hi, 32'h0};
      x_r <= m ^ (m >> 27);
    end
    if (cmd.mix4) begin
      p_r <= 64'(xs[31:0] * MixMul2[31:0]);
    end
    if (cmd.mix5) begin
      logic [31:0] hi;
      logic [63:0] m, f;
      hi = 32'(xs[63:32] * MixMul2[31:0]) + 32'(xs[31:0] * MixMul2[63:32]);
      m  = p_r + {hi, 32'h0};
      f  = m ^ (m >> 31);
      idx_r <= f[MW-1:0];
    end
    if (cmd.load && in_data.op == OP_READ) begin
      idx_r <= in_data.read_index[MW-1:0];
    end
  end

  // Counter memory: clear sweep, registered read, increment write.
  always_ff @(posedge clk) begin
    if (cmd.clear_step && !clr_r[MW]) begin
      cmap[clr_r[MW-1:0]] <= '0;
    end else if (cmd.map_wr) begin
      cmap[idx_r] <= cval_r + 8'd1;
    end
    if (cmd.map_rd) begin
      cval_r <= cmap[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r <= '0;
    end else if (cmd.make_zero) begin
      res_r <= '0;
    end else if (cmd.map_wr) begin
      res_r.fed         <= 1'b1;
      res_r.map_index   <= 16'(idx_r);
      res_r.count_value <= cval_r + 8'd1;
    end else if (cmd.map_rd && op_r == OP_READ) begin
      res_r.fed         <= 1'b0;
      res_r.map_index   <= 16'(idx_r);
      res_r.count_value <= cmap[idx_r];
    end
  end

endmodule

### verif/hashed_state_transition_counter_checker.sv
// ----------------------------------------------------------------------------
// hashed_state_transition_counter_checker: result predictor and comparator
// Watches both channels, predicts each result from its request and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_state_transition_counter_checker
  import hstc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  out_req_t out_data,
  output int       fail_count,
  output int       pending
);

  localparam int unsigned MapSize = MapEntriesDef;
  localparam int unsigned VarCount = NumVarsDef;
  localparam int unsigned TableDepth = FeedDef;

  logic [31:0] mach_tag;
  logic [31:0] mach_last;
  logic        mach_live;
  logic [31:0] sub_last;
  logic        sub_live;
  logic [7:0]  counters [MapSize];
  logic [31:0] value_table [VarCount][TableDepth];
  int          table_fill [VarCount];
  out_req_t    expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [63:0] splitmix(logic [63:0] x);
    x = (x ^ (x >> 30)) * MixMul1;
    x = (x ^ (x >> 27)) * MixMul2;
    return x ^ (x >> 31);
  endfunction

  function automatic out_req_t count_transition(logic [31:0] prior, logic [31:0] cur);
    logic [31:0] h;
    int unsigned idx;
    out_req_t r;
    h = 32'(splitmix({prior, cur}));
    idx = h % MapSize;
    counters[idx] = counters[idx] + 8'd1;
    r.fed = 1'b1;
    r.map_index = idx[15:0];
    r.count_value = counters[idx];
    return r;
  endfunction

  function automatic out_req_t feed_substate(logic [31:0] tag);
    logic [31:0] v;
    logic [31:0] prior;
    v = mach_tag ^ tag;
    prior = sub_live ? sub_last : v;
    sub_last = v;
    sub_live = 1'b1;
    return count_transition(prior, v);
  endfunction

  function automatic out_req_t predict_result(in_req_t req);
    logic [31:0] tag;
    logic [31:0] prior;
    out_req_t r;
    bit hit;
    int n;
    tag = ({16'd0, req.var_id} << 16) + req.var_value;
    r = '0;
    case (req.op)
      OP_MACHINE: begin
        prior = mach_live ? mach_last : tag;
        mach_tag = tag;
        mach_last = tag;
        mach_live = 1'b1;
        r = count_transition(prior, tag);
      end
      OP_SUB: r = feed_substate(tag);
      OP_SINGLE: begin
        if (req.var_id < VarCount) begin
          n = table_fill[req.var_id];
          hit = 0;
          for (int i = 0; i < n; i++) begin
            if (value_table[req.var_id][i] == tag) hit = 1;
          end
          if (!hit && n < TableDepth) begin
            value_table[req.var_id][n] = tag;
            table_fill[req.var_id] = n + 1;
            hit = 1;
          end
          if (hit) r = feed_substate(tag);
        end
      end
      OP_READ: begin
        r.map_index = 16'(req.read_index % MapSize);
        r.count_value = counters[req.read_index % MapSize];
      end
      OP_NEWRUN: begin
        mach_tag = '0;
        mach_last = '0;
        mach_live = 1'b0;
        sub_last = '0;
        sub_live = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    mach_tag = '0;
    mach_last = '0;
    mach_live = 1'b0;
    sub_last = '0;
    sub_live = 1'b0;
    foreach (counters[i]) counters[i] = '0;
    foreach (table_fill[i]) table_fill[i] = 0;
  end

  always @(posedge clk) begin
    out_req_t want;
    if (rst_n && in_valid && in_ready) expected_results.push_back(predict_result(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        if (out_data.fed !== want.fed)
          report_mismatch($sformatf("fed %0b, want %0b", out_data.fed, want.fed));
        if (out_data.map_index !== want.map_index)
          report_mismatch($sformatf("map_index %0h, want %0h",
                                    out_data.map_index, want.map_index));
        if (out_data.count_value !== want.count_value)
          report_mismatch($sformatf("count_value %0d, want %0d",
                                    out_data.count_value, want.count_value));
      end
    end
  end

endmodule

### verif/hashed_state_transition_counter_test.sv
// ----------------------------------------------------------------------------
// hashed_state_transition_counter_test: testbench top
// Drives directed and random requests with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_state_transition_counter_test;
  import hstc_pkg::*;

  localparam int RandomRequests = 1400;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_data;
  int       fail_count;
  int       pending;
  bit       calm = 0;
  bit       hold_off = 0;
  bit       send_done = 0;

  always #2 clk = ~clk;

  hashed_state_transition_counter u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  hashed_state_transition_counter_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  task automatic send_request(logic [2:0] op, logic [15:0] id, logic [31:0] value,
                              logic [15:0] ridx);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= '{op: op, var_id: id, var_value: value, read_index: ridx};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly small identifiers and few distinct values, so tables fill and repeat.
  task automatic send_random();
    logic [2:0] op;
    logic [15:0] id;
    logic [31:0] value;
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) op = OP_MACHINE;
    else if (pick < 45) op = OP_SUB;
    else if (pick < 80) op = OP_SINGLE;
    else if (pick < 90) op = OP_READ;
    else if (pick < 95) op = OP_NEWRUN;
    else op = 3'($urandom_range(7));
    id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
    value = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(24));
    send_request(op, id, value, 16'($urandom));
  endtask

  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 32);
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: field extremes, every named op, two undefined ops and each special case.
    send_request(OP_READ, 16'd0, 32'd0, 16'hffff);
    send_request(OP_MACHINE, 16'hffff, 32'hffffffff, 16'd0);
    send_request(OP_MACHINE, 16'd0, 32'h80000000, 16'hffff);
    send_request(OP_MACHINE, 16'd0, 32'h7fffffff, 16'd0);
    send_request(OP_SUB, 16'hffff, 32'hffffffff, 16'd0);
    send_request(OP_SUB, 16'd0, 32'd0, 16'd0);
    for (int i = 0; i < 18; i++) send_request(OP_SINGLE, 16'd255, 32'(i % 17), 16'd0);
    send_request(OP_SINGLE, 16'd256, 32'd1, 16'd0);
    send_request(OP_SINGLE, 16'hffff, 32'd1, 16'd0);
    send_request(OP_NEWRUN, 16'd0, 32'd0, 16'd0);
    send_request(3'd5, 16'd0, 32'd0, 16'd0);
    send_request(3'd7, 16'hffff, 32'hffffffff, 16'hffff);
    send_request(OP_MACHINE, 16'd1, 32'd2, 16'd0);
    for (int i = 0; i < RandomRequests; i++) begin
      calm = (i >= 600 && i < 800);
      send_random();
    end
    in_valid <= 1'b0;
    send_done = 1;
  end

  // Long receiver hold-off while requests keep coming, once the clearing
  // sweep is over and requests flow.
  initial begin
    wait (rst_n);
    @(posedge clk iff in_ready);
    repeat (2000) @(posedge clk);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    wait (send_done);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
hw/rtl/hstc_pkg.sv
hw/rtl/hstc_ctrl.sv
hw/rtl/hstc_dp.sv
hw/rtl/hashed_state_transition_counter.sv
verif/hashed_state_transition_counter_checker.sv
verif/hashed_state_transition_counter_test.sv
